/* src/dhkv_pkg.sv */
`default_nettype none

package dhkv_pkg;

	// table geometry (prime slot count)
	localparam int SLOT_COUNT = 127;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	// wide enough for index plus step and for the running remainder shifted by one
	localparam int SUM_W      = $clog2(2 * SLOT_COUNT + 8);

	localparam int KEY_W      = 32;
	localparam int VAL_W      = 64;
	localparam int STATUS_W   = 3;
	localparam int ENTRY_W    = 1 + KEY_W + VAL_W;

	// remainder unit: key bits consumed per cycle
	localparam int DIGITS     = 4;
	localparam int HASH_STEPS = KEY_W / DIGITS;
	localparam int HSTEP_W    = $clog2(HASH_STEPS);

	// secondary hash modulus
	localparam int STEP_MOD   = 7;
	localparam int R7_W       = 4;

	// the key is biased by 2^31 before reduction; these undo the bias
	localparam longint OFF_M  = (64'd1 << (KEY_W - 1)) % SLOT_COUNT;
	localparam longint OFF_7  = (64'd1 << (KEY_W - 1)) % STEP_MOD;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_HIT      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;

	typedef struct packed {
		logic clear_wr;
		logic load_item;
		logic hash_step;
		logic hash_fix;
		logic probe_issue;
		logic probe_eval;
		logic res_load;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic hash_last;
		logic stop;
	} sts_t;

endpackage

`default_nettype wire

/* src/dhkv_datapath.sv */
`default_nettype none

module dhkv_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire dhkv_pkg::cmd_t                      cmd,
	output dhkv_pkg::sts_t                           sts,
	input  wire logic                                mode,
	input  wire logic signed [dhkv_pkg::KEY_W-1:0]   key,
	input  wire logic [dhkv_pkg::VAL_W-1:0]          value,
	output logic [dhkv_pkg::STATUS_W-1:0]            status,
	output logic [dhkv_pkg::VAL_W-1:0]               found_value
);

	logic                            mode_q;
	logic [dhkv_pkg::KEY_W-1:0]      key_q;
	logic [dhkv_pkg::VAL_W-1:0]      val_q;
	logic [dhkv_pkg::KEY_W-1:0]      sh_q;
	logic [dhkv_pkg::SUM_W-1:0]      rm_q;
	logic [dhkv_pkg::R7_W-1:0]       r7_q;
	logic [dhkv_pkg::HSTEP_W-1:0]    dig_q;
	logic [dhkv_pkg::SLOT_W-1:0]     idx_q;
	logic [dhkv_pkg::SLOT_W-1:0]     step_q;
	logic [dhkv_pkg::SLOT_W-1:0]     ecnt_q;
	logic [dhkv_pkg::ENTRY_W-1:0]    rd_s1;
	logic [dhkv_pkg::SLOT_W-1:0]     ridx_s1;
	logic [dhkv_pkg::STATUS_W-1:0]   res_status_q;
	logic [dhkv_pkg::VAL_W-1:0]      res_found_q;
	logic [dhkv_pkg::STATUS_W-1:0]   status_q;
	logic [dhkv_pkg::VAL_W-1:0]      found_q;

	logic [dhkv_pkg::ENTRY_W-1:0]    mem [dhkv_pkg::SLOT_COUNT];

	logic [dhkv_pkg::SUM_W-1:0]      rm_nxt;
	logic [dhkv_pkg::R7_W-1:0]       r7_nxt;
	logic [dhkv_pkg::SUM_W-1:0]      h1;
	logic [dhkv_pkg::R7_W-1:0]       r7c;
	logic [dhkv_pkg::SUM_W-1:0]      step_red;
	logic [dhkv_pkg::SUM_W-1:0]      idx_sum;
	logic [dhkv_pkg::SLOT_W-1:0]     idx_nxt;
	logic                            occ;
	logic                            hit;
	logic                            empty;
	logic                            last;
	logic [dhkv_pkg::STATUS_W-1:0]   res_status;
	logic [dhkv_pkg::VAL_W-1:0]      res_found;
	logic                            wr_en;
	logic [dhkv_pkg::SLOT_W-1:0]     wr_addr;
	logic [dhkv_pkg::ENTRY_W-1:0]    wr_data;

	localparam logic [dhkv_pkg::SUM_W-1:0] M_S   = dhkv_pkg::SUM_W'(dhkv_pkg::SLOT_COUNT);
	localparam logic [dhkv_pkg::SUM_W-1:0] OFF_S = dhkv_pkg::SUM_W'(dhkv_pkg::OFF_M);
	localparam logic [dhkv_pkg::R7_W-1:0]  M7    = dhkv_pkg::R7_W'(dhkv_pkg::STEP_MOD);
	localparam logic [dhkv_pkg::R7_W-1:0]  OFF7  = dhkv_pkg::R7_W'(dhkv_pkg::OFF_7);

	// restoring remainder, a few key bits per cycle, msb first
	always_comb begin
		logic [dhkv_pkg::SUM_W-1:0] vm;
		logic [dhkv_pkg::R7_W-1:0]  v7;
		vm = rm_q;
		v7 = r7_q;
		for (int j = 0; j < dhkv_pkg::DIGITS; j++) begin
			vm = {vm[dhkv_pkg::SUM_W-2:0], sh_q[dhkv_pkg::KEY_W-1-j]};
			if (vm >= M_S) begin
				vm = vm - M_S;
			end
			v7 = {v7[dhkv_pkg::R7_W-2:0], sh_q[dhkv_pkg::KEY_W-1-j]};
			if (v7 >= M7) begin
				v7 = v7 - M7;
			end
		end
		rm_nxt = vm;
		r7_nxt = v7;
	end

	// remove the bias, form first slot and step
	always_comb begin
		logic [dhkv_pkg::SUM_W-1:0] s;
		if (rm_q >= OFF_S) begin
			h1 = rm_q - OFF_S;
		end else begin
			h1 = rm_q + M_S - OFF_S;
		end
		if (r7_q >= OFF7) begin
			r7c = r7_q - OFF7;
		end else begin
			r7c = r7_q + M7 - OFF7;
		end
		s = dhkv_pkg::SUM_W'(M7 - r7c);
		// small tables: step may exceed the slot count
		if (s >= M_S) begin
			s = s - M_S;
		end
		if (s >= M_S) begin
			s = s - M_S;
		end
		step_red = s;
	end

	always_comb begin
		idx_sum = dhkv_pkg::SUM_W'(idx_q) + dhkv_pkg::SUM_W'(step_q);
		if (idx_sum >= M_S) begin
			idx_sum = idx_sum - M_S;
		end
		idx_nxt = idx_sum[dhkv_pkg::SLOT_W-1:0];
	end

	// probe evaluation on the registered slot
	assign occ   = rd_s1[dhkv_pkg::ENTRY_W-1];
	assign hit   = occ && (rd_s1[dhkv_pkg::VAL_W +: dhkv_pkg::KEY_W] == key_q);
	assign empty = !occ;
	assign last  = (ecnt_q == dhkv_pkg::SLOT_W'(dhkv_pkg::SLOT_COUNT - 1));

	always_comb begin
		res_found = '0;
		priority if (hit) begin
			if (mode_q == dhkv_pkg::MODE_SEARCH) begin
				res_status = dhkv_pkg::ST_HIT;
				res_found  = rd_s1[dhkv_pkg::VAL_W-1:0];
			end else begin
				res_status = dhkv_pkg::ST_UPDATED;
			end
		end else if (empty) begin
			res_status = (mode_q == dhkv_pkg::MODE_SEARCH) ? dhkv_pkg::ST_MISS
				: dhkv_pkg::ST_INSERTED;
		end else begin
			res_status = (mode_q == dhkv_pkg::MODE_SEARCH) ? dhkv_pkg::ST_MISS
				: dhkv_pkg::ST_FULL;
		end
	end

	assign wr_en   = cmd.clear_wr
		|| (cmd.probe_eval && (mode_q == dhkv_pkg::MODE_INSERT) && (hit || empty));
	assign wr_addr = cmd.clear_wr ? idx_q : ridx_s1;
	assign wr_data = cmd.clear_wr ? '0 : {1'b1, key_q, val_q};

	assign sts.clr_last  = (idx_q == dhkv_pkg::SLOT_W'(dhkv_pkg::SLOT_COUNT - 1));
	assign sts.hash_last = (dig_q == dhkv_pkg::HSTEP_W'(dhkv_pkg::HASH_STEPS - 1));
	assign sts.stop      = hit || empty || last;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.probe_issue) begin
			rd_s1   <= mem[idx_q];
			ridx_s1 <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else begin
			priority if (cmd.clear_wr) begin
				idx_q <= idx_q + 1'b1;
			end else if (cmd.hash_fix) begin
				idx_q <= h1[dhkv_pkg::SLOT_W-1:0];
			end else if (cmd.probe_issue) begin
				idx_q <= idx_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mode_q <= mode;
			key_q  <= key;
			val_q  <= value;
			sh_q   <= {~key[dhkv_pkg::KEY_W-1], key[dhkv_pkg::KEY_W-2:0]};
			rm_q   <= '0;
			r7_q   <= '0;
			dig_q  <= '0;
		end else if (cmd.hash_step) begin
			sh_q  <= sh_q << dhkv_pkg::DIGITS;
			rm_q  <= rm_nxt;
			r7_q  <= r7_nxt;
			dig_q <= dig_q + 1'b1;
		end
		if (cmd.hash_fix) begin
			step_q <= step_red[dhkv_pkg::SLOT_W-1:0];
			ecnt_q <= '0;
		end else if (cmd.probe_eval) begin
			ecnt_q <= ecnt_q + 1'b1;
		end
		if (cmd.res_load) begin
			res_status_q <= res_status;
			res_found_q  <= res_found;
		end
		if (cmd.out_load) begin
			status_q <= res_status_q;
			found_q  <= res_found_q;
		end
	end

	assign status      = status_q;
	assign found_value = found_q;

endmodule

`default_nettype wire

/* src/dhkv_ctrl.sv */
`default_nettype none

module dhkv_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire dhkv_pkg::sts_t  sts,
	output dhkv_pkg::cmd_t       cmd
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HASH  = 3'd2;
	localparam logic [2:0] S_FIX   = 3'd3;
	localparam logic [2:0] S_ISSUE = 3'd4;
	localparam logic [2:0] S_PROBE = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_nxt     = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash_step = 1'b1;
				if (sts.hash_last) begin
					state_nxt = S_FIX;
				end
			end
			S_FIX: begin
				cmd.hash_fix = 1'b1;
				state_nxt    = S_ISSUE;
			end
			S_ISSUE: begin
				cmd.probe_issue = 1'b1;
				state_nxt       = S_PROBE;
			end
			S_PROBE: begin
				cmd.probe_eval = 1'b1;
				if (sts.stop) begin
					cmd.res_load = 1'b1;
					state_nxt    = S_DONE;
				end else begin
					cmd.probe_issue = 1'b1;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* src/double_hash_key_value_table.sv */
`default_nettype none

// open-addressing key/value table with double hashing over a prime number of slots
// (dhkv_pkg::SLOT_COUNT, 127 as built). each input word is an insert/update (mode 0)
// or a search (mode 1) on a signed 32-bit key; each gives exactly one output word.
// first probe is key mod slot count, step is 7 - (key mod 7), both made non-negative;
// at most slot-count probes are made. after reset the block sweeps the slot memory
// once, one slot a cycle, and takes no input word until the sweep is done. each
// accepted word then passes through the remainder unit (4 key bits a cycle), a step
// that forms first slot and step, the issue of the first read, one probe per read at
// the single read port of the slot memory, and then the load of its result register.
// a result waiting on the output does not stop the next word from being accepted.
// found_value is zero except on a hit.
module double_hash_key_value_table (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input channel
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                mode,
	input  wire logic signed [dhkv_pkg::KEY_W-1:0]   key,
	input  wire logic [dhkv_pkg::VAL_W-1:0]          value,
	// output channel
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [dhkv_pkg::STATUS_W-1:0]            status,
	output logic [dhkv_pkg::VAL_W-1:0]               found_value
);

	dhkv_pkg::cmd_t cmd;
	dhkv_pkg::sts_t sts;

	// sequencer: clearing sweep, hashing, probe loop, result hand-off
	dhkv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// remainder unit, probe address arithmetic, slot memory and result registers
	dhkv_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.mode        (mode),
		.key         (key),
		.value       (value),
		.status      (status),
		.found_value (found_value)
	);

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	// cycles with no word moving on either channel before the run is abandoned;
	// the slowest word is the reset sweep plus a full probe run plus the longest stall
	localparam int IDLE_LIMIT  = 4000;
	// quiet time after the last result, a little over a full-probe word
	localparam int DRAIN_WAIT  = 160;
	localparam int REPORT_MAX  = 10;
	localparam int POOL_SIZE   = 48;

	typedef enum logic [1:0] {SLOT_FREE, SLOT_USED, SLOT_GONE} slot_mark_t;

	typedef struct {
		int                                    seq;
		logic [dhkv_pkg::STATUS_W-1:0]         status;
		logic [dhkv_pkg::VAL_W-1:0]            found;
	} outcome_t;

	logic                                  clk         = 1'b0;
	logic                                  arst_n      = 1'b0;
	logic                                  in_valid    = 1'b0;
	logic                                  in_ready;
	logic                                  mode        = dhkv_pkg::MODE_INSERT;
	logic signed [dhkv_pkg::KEY_W-1:0]     key         = '0;
	logic [dhkv_pkg::VAL_W-1:0]            value       = '0;
	logic                                  out_valid;
	logic                                  out_ready   = 1'b0;
	logic [dhkv_pkg::STATUS_W-1:0]         status;
	logic [dhkv_pkg::VAL_W-1:0]            found_value;

	// shadow copy of the slot memory, updated as each word is accepted
	logic signed [dhkv_pkg::KEY_W-1:0]     shadow_key   [dhkv_pkg::SLOT_COUNT];
	logic [dhkv_pkg::VAL_W-1:0]            shadow_value [dhkv_pkg::SLOT_COUNT];
	slot_mark_t                            shadow_mark  [dhkv_pkg::SLOT_COUNT];
	int                                    slots_used;
	// every key that went in as new, so later words can aim at stored entries
	logic signed [dhkv_pkg::KEY_W-1:0]     stored_keys[$];
	logic signed [dhkv_pkg::KEY_W-1:0]     key_pool[$];

	outcome_t                              pending_outcomes[$];
	int                                    words_sent;
	int                                    words_checked;
	int                                    error_count;
	int                                    idle_cycles;
	int                                    status_tally [8];
	// when set, neither side inserts gaps
	bit                                    no_idle;

	double_hash_key_value_table dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.key         (key),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.found_value (found_value)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// hash arithmetic on the signed key, remainders made non-negative
	// ---------------------------------------------------------------
	function automatic int home_slot(input logic signed [dhkv_pkg::KEY_W-1:0] k);
		longint r;
		r = longint'(k) % dhkv_pkg::SLOT_COUNT;
		if (r < 0)
			r += dhkv_pkg::SLOT_COUNT;
		return int'(r);
	endfunction

	function automatic int probe_stride(input logic signed [dhkv_pkg::KEY_W-1:0] k);
		longint r;
		r = longint'(k) % dhkv_pkg::STEP_MOD;
		if (r < 0)
			r += dhkv_pkg::STEP_MOD;
		return dhkv_pkg::STEP_MOD - int'(r);
	endfunction

	// walks the probe sequence over the shadow table and applies the word;
	// an insert stops at its own key or the first free slot, a search at its
	// own key or an empty slot, and either gives up after every slot was tried
	function automatic void table_apply(input logic m,
			input logic signed [dhkv_pkg::KEY_W-1:0] k,
			input logic [dhkv_pkg::VAL_W-1:0] v,
			output logic [dhkv_pkg::STATUS_W-1:0] st,
			output logic [dhkv_pkg::VAL_W-1:0] fv);
		int first;
		int stride;
		int s;
		first  = home_slot(k);
		stride = probe_stride(k);
		st     = (m == dhkv_pkg::MODE_SEARCH) ? dhkv_pkg::ST_MISS : dhkv_pkg::ST_FULL;
		fv     = '0;
		for (int i = 0; i < dhkv_pkg::SLOT_COUNT; i++) begin
			s = (first + i * stride) % dhkv_pkg::SLOT_COUNT;
			if (shadow_mark[s] == SLOT_USED && shadow_key[s] == k) begin
				if (m == dhkv_pkg::MODE_SEARCH) begin
					st = dhkv_pkg::ST_HIT;
					fv = shadow_value[s];
				end else begin
					shadow_value[s] = v;
					st = dhkv_pkg::ST_UPDATED;
				end
				break;
			end
			if (m == dhkv_pkg::MODE_SEARCH) begin
				if (shadow_mark[s] == SLOT_FREE)
					break;
			end else if (shadow_mark[s] != SLOT_USED) begin
				shadow_key[s]   = k;
				shadow_value[s] = v;
				shadow_mark[s]  = SLOT_USED;
				slots_used++;
				stored_keys = {stored_keys, k};
				st = dhkv_pkg::ST_INSERTED;
				break;
			end
		end
	endfunction

	// mostly no gap or a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [dhkv_pkg::VAL_W-1:0] random_value();
		return {$urandom, $urandom};
	endfunction

	function automatic logic signed [dhkv_pkg::KEY_W-1:0] random_key();
		return $urandom;
	endfunction

	// ---------------------------------------------------------------
	// input side: one word per call, called at a rising edge
	// ---------------------------------------------------------------
	task automatic send_word(input logic m, input logic signed [dhkv_pkg::KEY_W-1:0] k,
			input logic [dhkv_pkg::VAL_W-1:0] v);
		int gap;
		outcome_t want;
		gap = pick_gap();
		// valid only drops when a gap follows, so back-to-back words keep it high
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		key      <= k;
		value    <= v;
		do
			@(posedge clk);
		while (!in_ready);
		want.seq = words_sent;
		table_apply(m, k, v, want.status, want.found);
		pending_outcomes = {pending_outcomes, want};
		words_sent++;
	endtask

	// ---------------------------------------------------------------
	// output side: ready in random bursts, results checked in order
	// ---------------------------------------------------------------
	initial begin
		int burst;
		int stall;
		@(posedge clk);
		forever begin
			out_ready <= 1'b1;
			burst = $urandom_range(1, 12);
			repeat (burst) @(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_outcomes.size() == 0) begin
				if (error_count < REPORT_MAX)
					$display("unexpected result word: status %0d value %h", status,
						found_value);
				error_count++;
			end else begin
				want = pending_outcomes.pop_front();
				words_checked++;
				status_tally[want.status]++;
				if (status !== want.status || found_value !== want.found) begin
					if (error_count < REPORT_MAX)
						$display("word %0d mismatch: status exp %0d got %0d, value exp %h got %h",
							want.seq, want.status, status, want.found, found_value);
					error_count++;
				end
			end
		end
	end

	// watchdog: counts cycles in which no word moves on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("timeout: nothing moved for %0d cycles, %0d words still expected",
			IDLE_LIMIT, pending_outcomes.size());
		$display("CHECK FAILED");
		$finish;
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// extremes of key and value, both operations, update, miss at an empty slot,
	// stride of seven, negative keys and a chain of keys sharing one home slot
	task automatic test_directed_cases();
		send_word(dhkv_pkg::MODE_INSERT, 32'sd0, '0);
		send_word(dhkv_pkg::MODE_INSERT, 32'sh7FFF_FFFF, '1);
		send_word(dhkv_pkg::MODE_INSERT, 32'sh8000_0000, 64'h8000_0000_0000_0001);
		send_word(dhkv_pkg::MODE_INSERT, -32'sd1, 64'h5A5A_A5A5_0F0F_F0F0);
		send_word(dhkv_pkg::MODE_SEARCH, 32'sd0, '1);
		send_word(dhkv_pkg::MODE_SEARCH, 32'sh7FFF_FFFF, '0);
		send_word(dhkv_pkg::MODE_SEARCH, 32'sh8000_0000, '0);
		send_word(dhkv_pkg::MODE_SEARCH, -32'sd1, '0);
		// same key again overwrites the value in place
		send_word(dhkv_pkg::MODE_INSERT, 32'sd0, 64'hFFFF_FFFF_0000_0000);
		send_word(dhkv_pkg::MODE_SEARCH, 32'sd0, '0);
		// all of these land on home slot 5 and have to walk on
		send_word(dhkv_pkg::MODE_INSERT, 32'sd5, 64'h0000_0000_FFFF_FFFF);
		send_word(dhkv_pkg::MODE_INSERT, 32'sd132, 64'h1);
		send_word(dhkv_pkg::MODE_INSERT, 32'sd259, 64'h2);
		send_word(dhkv_pkg::MODE_INSERT, -32'sd122, 64'h3);
		send_word(dhkv_pkg::MODE_SEARCH, 32'sd259, '0);
		send_word(dhkv_pkg::MODE_SEARCH, -32'sd122, '0);
		// absent but homed on the busy chain, then absent on a quiet slot
		send_word(dhkv_pkg::MODE_SEARCH, 32'sd386, '0);
		send_word(dhkv_pkg::MODE_SEARCH, 32'sd12345, '0);
		// key divisible by seven gives the longest stride
		send_word(dhkv_pkg::MODE_INSERT, -32'sd7, random_value());
		send_word(dhkv_pkg::MODE_SEARCH, -32'sd7, '0);
		send_word(dhkv_pkg::MODE_INSERT, 32'sh7FFF_FFFE, '1);
		send_word(dhkv_pkg::MODE_SEARCH, 32'sh8000_0001, '0);
	endtask

	// random traffic over a small set of keys, so searches hit and inserts update
	// often; the set clusters on a few home slots and around the key extremes
	task automatic test_pooled_traffic(input int count);
		int home;
		int pick;
		logic signed [dhkv_pkg::KEY_W-1:0] k;
		for (int i = 0; i < POOL_SIZE; i++) begin
			pick = $urandom_range(0, 3);
			if (pick == 0) begin
				k = random_key();
			end else if (pick == 1) begin
				home = $urandom_range(0, 6);
				k = home + dhkv_pkg::SLOT_COUNT * ($urandom_range(0, 10) - 5);
			end else if (pick == 2) begin
				k = 32'sh7FFF_FFFF - $urandom_range(0, 300);
			end else begin
				k = 32'sh8000_0000 + $urandom_range(0, 300);
			end
			key_pool = {key_pool, k};
		end
		for (int i = 0; i < count; i++) begin
			// one stretch runs flat out on both sides
			no_idle = (i >= 200 && i < 300);
			// a slice of never-seen keys as noise
			if ($urandom_range(0, 9) == 0)
				k = random_key();
			else
				k = key_pool[$urandom_range(0, key_pool.size() - 1)];
			send_word(1'($urandom_range(0, 1)), k, random_value());
		end
		no_idle = 0;
	endtask

	// fresh keys until every slot is taken
	task automatic test_fill_to_capacity();
		while (slots_used < dhkv_pkg::SLOT_COUNT)
			send_word(dhkv_pkg::MODE_INSERT, random_key(), random_value());
	endtask

	// on a full table: hits with long probe runs, misses after a full probe,
	// updates in place and inserts turned away as full
	task automatic test_full_table(input int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				send_word(dhkv_pkg::MODE_SEARCH,
					stored_keys[$urandom_range(0, stored_keys.size() - 1)], random_value());
			else if (pick < 55)
				send_word(dhkv_pkg::MODE_SEARCH, random_key(), random_value());
			else if (pick < 80)
				send_word(dhkv_pkg::MODE_INSERT,
					stored_keys[$urandom_range(0, stored_keys.size() - 1)], random_value());
			else
				send_word(dhkv_pkg::MODE_INSERT, random_key(), random_value());
		end
	endtask

	// ---------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------
	initial begin
		for (int s = 0; s < dhkv_pkg::SLOT_COUNT; s++)
			shadow_mark[s] = SLOT_FREE;
		slots_used    = 0;
		words_sent    = 0;
		words_checked = 0;
		error_count   = 0;
		idle_cycles   = 0;
		no_idle       = 0;
		foreach (status_tally[i])
			status_tally[i] = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_pooled_traffic(900);
		test_fill_to_capacity();
		test_full_table(900);

		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		// anything arriving now is a stray result
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d words sent, %0d results checked, table filled to %0d of %0d slots",
			words_sent, words_checked, slots_used, dhkv_pkg::SLOT_COUNT);
		$display("new %0d, updated %0d, full %0d, hit %0d, miss %0d; %0d failures",
			status_tally[dhkv_pkg::ST_INSERTED], status_tally[dhkv_pkg::ST_UPDATED],
			status_tally[dhkv_pkg::ST_FULL], status_tally[dhkv_pkg::ST_HIT],
			status_tally[dhkv_pkg::ST_MISS], error_count);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
